/* rtl/tcw_pkg.sv */
// ============================================================================
// tcw_pkg
// Shared types and constants for the text console writer: item and result
// payloads, command codes, controller states and controller/datapath links.
// ============================================================================
package tcw_pkg;

    // Commands carried by an input item.
    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_SET   = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    // Configuration register indexes.
    localparam logic REG_FOREGROUND = 1'b0;
    localparam logic REG_BACKGROUND = 1'b1;

    localparam logic [3:0] RESET_FOREGROUND = 4'd7;
    localparam logic [3:0] RESET_BACKGROUND = 4'd0;

    // Control characters and the blank.
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_BLANK     = 8'h20;

    localparam int TAB_WIDTH = 8;

    typedef struct packed {
        cmd_t        command;
        logic [7:0]  char_code;
        logic [7:0]  new_col;
        logic [7:0]  new_row;
        logic [10:0] cell_index;
    } in_item_t;

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_position;
        logic        scrolled;
        logic [15:0] cell_word;
    } out_item_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_MOVE,
        S_FILL
    } state_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_ZERO,
        CNT_INC
    } cnt_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_item;
        logic    put_exec;
        logic    set_exec;
        logic    clear_cursor;
        logic    read_cell;
        logic    move_en;
        logic    fill_en;
        logic    fill_reset;
        cnt_op_t cnt_op;
        logic    finish;
        logic    finish_scrolled;
        logic    finish_read;
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t command;
        logic need_scroll;
        logic cnt_move_end;
        logic cnt_last;
    } stat_t;

endpackage

/* rtl/tcw_ctrl.sv */
// ============================================================================
// tcw_ctrl
// Controller state machine: sequences the power-up clear, command execution,
// the scroll copy and the blank fill.
// ============================================================================
module tcw_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  tcw_pkg::stat_t stat,
    output tcw_pkg::ctrl_t ctrl,
    output logic           busy
);

    tcw_pkg::state_t state_reg;
    tcw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcw_pkg::S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != tcw_pkg::S_IDLE);

    always_comb
    begin
        state_next           = state_reg;
        ctrl                 = '0;
        ctrl.cnt_op          = tcw_pkg::CNT_HOLD;
        unique case (state_reg)
            tcw_pkg::S_INIT:
            begin
                ctrl.fill_en    = 1'b1;
                ctrl.fill_reset = 1'b1;
                ctrl.cnt_op     = tcw_pkg::CNT_INC;
                if (stat.cnt_last)
                begin
                    ctrl.cnt_op = tcw_pkg::CNT_ZERO;
                    state_next  = tcw_pkg::S_IDLE;
                end
            end
            tcw_pkg::S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load_item = 1'b1;
                    state_next     = tcw_pkg::S_EXEC;
                end
            end
            tcw_pkg::S_EXEC:
            begin
                unique case (stat.command)
                    tcw_pkg::CMD_PUT:
                    begin
                        ctrl.put_exec = 1'b1;
                        if (stat.need_scroll)
                        begin
                            ctrl.cnt_op = tcw_pkg::CNT_ZERO;
                            state_next  = tcw_pkg::S_MOVE;
                        end
                        else
                        begin
                            ctrl.finish = 1'b1;
                            state_next  = tcw_pkg::S_IDLE;
                        end
                    end
                    tcw_pkg::CMD_CLEAR:
                    begin
                        ctrl.clear_cursor = 1'b1;
                        ctrl.cnt_op       = tcw_pkg::CNT_ZERO;
                        state_next        = tcw_pkg::S_FILL;
                    end
                    tcw_pkg::CMD_SET:
                    begin
                        ctrl.set_exec = 1'b1;
                        ctrl.finish   = 1'b1;
                        state_next    = tcw_pkg::S_IDLE;
                    end
                    tcw_pkg::CMD_READ:
                    begin
                        ctrl.read_cell = 1'b1;
                        state_next     = tcw_pkg::S_READ;
                    end
                    default:
                    begin
                        state_next = tcw_pkg::S_IDLE;
                    end
                endcase
            end
            tcw_pkg::S_READ:
            begin
                ctrl.finish      = 1'b1;
                ctrl.finish_read = 1'b1;
                state_next       = tcw_pkg::S_IDLE;
            end
            tcw_pkg::S_MOVE:
            begin
                ctrl.move_en = 1'b1;
                if (stat.cnt_move_end)
                begin
                    ctrl.cnt_op = tcw_pkg::CNT_HOLD;
                    state_next  = tcw_pkg::S_FILL;
                end
                else
                begin
                    ctrl.cnt_op = tcw_pkg::CNT_INC;
                end
            end
            tcw_pkg::S_FILL:
            begin
                ctrl.fill_en = 1'b1;
                if (stat.cnt_last)
                begin
                    ctrl.finish          = 1'b1;
                    ctrl.finish_scrolled = (stat.command == tcw_pkg::CMD_PUT);
                    state_next           = tcw_pkg::S_IDLE;
                end
                else
                begin
                    ctrl.cnt_op = tcw_pkg::CNT_INC;
                end
            end
            default:
            begin
                state_next = tcw_pkg::S_INIT;
            end
        endcase
    end

endmodule

/* rtl/tcw_datapath.sv */
// ============================================================================
// tcw_datapath
// Screen store, cursor, color registers, sweep counter and result register.
// ============================================================================
module tcw_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcw_pkg::in_item_t    item,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [3:0]           cfg_data,
    input  tcw_pkg::ctrl_t       ctrl,
    output tcw_pkg::stat_t       stat,
    output logic                 done,
    output tcw_pkg::out_item_t   result
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int TW    = CW + 4;

    logic [15:0] mem [CELLS];

    tcw_pkg::in_item_t  item_reg;
    tcw_pkg::out_item_t result_reg;
    tcw_pkg::out_item_t result_next;
    logic               done_reg;
    logic [3:0]         fg_reg;
    logic [3:0]         bg_reg;
    logic [CW-1:0]      col_reg;
    logic [CW-1:0]      col_next;
    logic [RW-1:0]      row_reg;
    logic [RW-1:0]      row_next;
    logic [AW-1:0]      cnt_reg;
    logic [AW-1:0]      cnt_next;
    logic [15:0]        rd_data_reg;

    logic [7:0]    attr;
    logic [TW-1:0] col_ext;
    logic [TW-1:0] put_col;
    logic [RW:0]   put_row_ext;
    logic          put_row_inc;
    logic          put_write;
    logic          put_scroll;
    logic [CW-1:0] put_col_fin;
    logic [RW-1:0] put_row_fin;
    logic          set_ok;
    logic          read_ok;
    logic [AW-1:0] cur_pos;
    logic [AW-1:0] pos_next;

    logic          we;
    logic [AW-1:0] wa;
    logic [15:0]   wd;
    logic          re;
    logic [AW-1:0] ra;

    assign attr    = {bg_reg, fg_reg};
    assign cur_pos = AW'(row_reg) * AW'(COLUMNS) + AW'(col_reg);

    // Cursor motion for a put command.
    always_comb
    begin
        col_ext     = TW'(col_reg);
        put_col     = col_ext;
        put_row_inc = 1'b0;
        put_write   = 1'b0;
        unique case (item_reg.char_code)
            tcw_pkg::CH_NEWLINE:
            begin
                put_col     = '0;
                put_row_inc = 1'b1;
            end
            tcw_pkg::CH_RETURN:
            begin
                put_col = '0;
            end
            tcw_pkg::CH_TAB:
            begin
                put_col = (col_ext + TW'(tcw_pkg::TAB_WIDTH))
                          & ~TW'(tcw_pkg::TAB_WIDTH - 1);
            end
            tcw_pkg::CH_BACKSPACE:
            begin
                put_col = (col_ext == '0) ? '0 : col_ext - TW'(1);
            end
            default:
            begin
                put_col   = col_ext + TW'(1);
                put_write = 1'b1;
            end
        endcase
        if (put_col >= TW'(COLUMNS))
        begin
            put_col     = '0;
            put_row_inc = 1'b1;
        end
        put_row_ext = {1'b0, row_reg} + {{RW{1'b0}}, put_row_inc};
        put_scroll  = (put_row_ext >= (RW + 1)'(ROWS));
        put_col_fin = CW'(put_col);
        put_row_fin = put_scroll ? RW'(ROWS - 1) : RW'(put_row_ext);
    end

    assign set_ok  = (32'(item_reg.new_col) < 32'(COLUMNS))
                     && (32'(item_reg.new_row) < 32'(ROWS));
    assign read_ok = (32'(item_reg.cell_index) < 32'(CELLS));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (ctrl.put_exec)
        begin
            col_next = put_col_fin;
            row_next = put_row_fin;
        end
        else if (ctrl.set_exec && set_ok)
        begin
            col_next = CW'(item_reg.new_col);
            row_next = RW'(item_reg.new_row);
        end
        else if (ctrl.clear_cursor)
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    assign pos_next = AW'(row_next) * AW'(COLUMNS) + AW'(col_next);

    always_comb
    begin
        result_next.cursor_col      = 7'(col_next);
        result_next.cursor_row      = 5'(row_next);
        result_next.cursor_position = 11'(pos_next);
        result_next.scrolled        = ctrl.finish_scrolled;
        result_next.cell_word       = (ctrl.finish_read && read_ok) ? rd_data_reg : 16'd0;
    end

    always_comb
    begin
        unique case (ctrl.cnt_op)
            tcw_pkg::CNT_ZERO: cnt_next = '0;
            tcw_pkg::CNT_INC:  cnt_next = cnt_reg + AW'(1);
            default:           cnt_next = cnt_reg;
        endcase
    end

    // Store port selection. A scroll copy reads one row ahead of the counter and
    // writes the registered data in the next cycle, one row above where it was read.
    always_comb
    begin
        we = 1'b0;
        wa = cnt_reg;
        wd = {attr, tcw_pkg::CH_BLANK};
        re = 1'b0;
        ra = AW'(item_reg.cell_index);
        if (ctrl.fill_en)
        begin
            we = 1'b1;
            if (ctrl.fill_reset)
            begin
                wd = {tcw_pkg::RESET_BACKGROUND, tcw_pkg::RESET_FOREGROUND, tcw_pkg::CH_BLANK};
            end
        end
        else if (ctrl.move_en)
        begin
            we = (cnt_reg != '0);
            wa = cnt_reg - AW'(1);
            wd = rd_data_reg;
            re = !stat.cnt_move_end;
            ra = cnt_reg + AW'(COLUMNS);
        end
        else if (ctrl.put_exec)
        begin
            we = put_write;
            wa = cur_pos;
            wd = {attr, item_reg.char_code};
        end
        else if (ctrl.read_cell)
        begin
            re = read_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd_data_reg <= mem[ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            item_reg <= item;
        end
        if (ctrl.finish)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg   <= tcw_pkg::RESET_FOREGROUND;
            bg_reg   <= tcw_pkg::RESET_BACKGROUND;
            col_reg  <= '0;
            row_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == tcw_pkg::REG_FOREGROUND))
            begin
                fg_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == tcw_pkg::REG_BACKGROUND))
            begin
                bg_reg <= cfg_data;
            end
            col_reg  <= col_next;
            row_reg  <= row_next;
            cnt_reg  <= cnt_next;
            done_reg <= ctrl.finish;
        end
    end

    assign stat.command      = item_reg.command;
    assign stat.need_scroll  = put_scroll;
    assign stat.cnt_move_end = (cnt_reg == AW'(CELLS - COLUMNS));
    assign stat.cnt_last     = (cnt_reg == AW'(CELLS - 1));

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* rtl/text_console_writer_top.sv */
// ============================================================================
// text_console_writer_top
// Text-mode console engine: a screen store of 16-bit cells (attribute in the
// high byte, character in the low byte) and a cursor, driven by put, clear,
// set-cursor and read-cell commands.
// ============================================================================
//
// Channel   Handshake              Payload              Direction
// -------   ---------------------  -------------------  ---------
// command   start & !busy          item   (in_item_t)   in
// result    done, one cycle        result (out_item_t)  out
// config    cfg_we                 cfg_index, cfg_data  in
//
// After reset the block sweeps the whole store, one cell per cycle, writing
// blanks in the reset attribute; busy stays high until the sweep ends.
// A put without scroll, and a set cursor, pass from accept through the
// execute state to the done strobe; a read cell adds a read state, since
// the store read data is registered. Clear fills the whole store with
// blanks; a put that scrolls first copies ROWS*COLUMNS - COLUMNS cells one
// row up, each written from its registered read, then fills COLUMNS blanks,
// all through the single store write port at one cell per cycle. The next
// item is accepted in the cycle done shows. Each result is shown for exactly
// one cycle; the receiver cannot stall it.
//
module text_console_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic               clk,
    input  logic               rst_n,
    // Command channel.
    input  logic               start,
    output logic               busy,
    input  tcw_pkg::in_item_t  item,
    // Result channel.
    output logic               done,
    output tcw_pkg::out_item_t result,
    // Configuration: register 0 is the foreground color, 1 the background.
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [3:0]         cfg_data
);

    // The controller only sees status and only issues commands; all state
    // that holds screen contents or cursor lives in the datapath.
    tcw_pkg::ctrl_t ctrl;
    tcw_pkg::stat_t stat;
    logic           busy_int;

    tcw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy_int)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

    assign busy = busy_int;

endmodule

/* dv/tb_text_console_writer_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_text_console_writer_top
// Self-checking bench for the text console writer. A queue of pending
// commands feeds a clocked driver, a clocked monitor checks every result
// against a cycle-free model of the screen store and cursor, and the colors
// are changed between phases while the block is idle.
// ============================================================================
module tb_text_console_writer_top;

    // Geometry under test, passed to the block so both sides agree.
    localparam int COLS      = 80;
    localparam int ROW_COUNT = 25;
    localparam int CELLS     = COLS * ROW_COUNT;

    // Items per random phase; six phases give roughly 750 items in all.
    localparam int PHASE_ITEMS = 125;
    localparam int PHASES      = 6;

    // Cycles to linger after the last result, well past the read latency.
    localparam int TAIL_CYCLES = 20;

    // Fixed time limit. The slowest legal run makes every item a scroll
    // followed by the longest sender gap, which is roughly 18 ms for under
    // 900 items; the limit is about eight times that.
    localparam longint TIME_LIMIT_NS = 150_000_000;

    // ------------------------------------------------------------------------
    // Block signals. Every input holds a known value from time zero.
    // ------------------------------------------------------------------------
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic               busy;
    tcw_pkg::in_item_t  item      = '0;
    logic               done;
    tcw_pkg::out_item_t result;
    logic               cfg_we    = 1'b0;
    logic               cfg_index = 1'b0;
    logic [3:0]         cfg_data  = 4'd0;

    text_console_writer_top #(
        .COLUMNS (COLS),
        .ROWS    (ROW_COUNT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Pending work for the driver. Besides command items, the queue carries
    // color writes and drain markers; both of those are held back until the
    // block is idle with every result collected.
    // ------------------------------------------------------------------------
    typedef enum logic [1:0] {
        WORK_ITEM,
        WORK_COLOR,
        WORK_DRAIN
    } work_kind_t;

    typedef struct {
        work_kind_t        kind;
        tcw_pkg::in_item_t cmd_item;
        logic              color_sel;
        logic [3:0]        color_value;
    } work_entry_t;

    work_entry_t        command_backlog[$];
    tcw_pkg::out_item_t expected_reports[$];

    // ------------------------------------------------------------------------
    // Screen model: the store, the cursor and the two color registers, kept
    // at the values the block should hold after every accepted item.
    // ------------------------------------------------------------------------
    logic [15:0] screen_model [0:CELLS-1];
    int unsigned model_col;
    int unsigned model_row;
    logic [3:0]  model_fg;
    logic [3:0]  model_bg;

    // Tallies for the closing summary and the verdict.
    int mismatches   = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int puts_sent    = 0;
    int scrolls_due  = 0;
    int clears_sent  = 0;
    int sets_sent    = 0;
    int reads_sent   = 0;
    int color_writes = 0;

    // Sender pacing: a burst of items, then a gap of idle cycles.
    int burst_left = 8;
    int gap_left   = 0;

    // Generator bookkeeping: items queued so far, and the row of the last
    // on-screen cursor move, which steers reads toward cells just written.
    int gen_items = 0;
    int gen_row   = 0;

    // Fills a range of cells with blanks in the current attribute.
    function automatic void blank_cells(int unsigned from, int unsigned upto);
        for (int unsigned i = from; i < upto; i++)
        begin
            screen_model[i] = {model_bg, model_fg, tcw_pkg::CH_BLANK};
        end
    endfunction

    function automatic void reset_screen_model();
        model_fg  = tcw_pkg::RESET_FOREGROUND;
        model_bg  = tcw_pkg::RESET_BACKGROUND;
        model_col = 0;
        model_row = 0;
        blank_cells(0, CELLS);
    endfunction

    // Runs one command against the model and returns the report the block
    // should produce for it.
    function automatic tcw_pkg::out_item_t apply_console_command(
        tcw_pkg::in_item_t cmd_item);
        tcw_pkg::out_item_t rep;
        int unsigned        pos;
        logic               rolled;
        rep    = '0;
        rolled = 1'b0;
        case (cmd_item.command)
            tcw_pkg::CMD_PUT:
            begin
                if (cmd_item.char_code == tcw_pkg::CH_NEWLINE)
                begin
                    model_col = 0;
                    model_row++;
                end
                else if (cmd_item.char_code == tcw_pkg::CH_RETURN)
                begin
                    model_col = 0;
                end
                else if (cmd_item.char_code == tcw_pkg::CH_TAB)
                begin
                    model_col = (model_col + tcw_pkg::TAB_WIDTH)
                                & ~(tcw_pkg::TAB_WIDTH - 1);
                end
                else if (cmd_item.char_code == tcw_pkg::CH_BACKSPACE)
                begin
                    // Backspace only moves the cursor; nothing is erased.
                    if (model_col > 0)
                    begin
                        model_col--;
                    end
                end
                else
                begin
                    pos = model_row * COLS + model_col;
                    if (pos < CELLS)
                    begin
                        screen_model[pos] = {model_bg, model_fg, cmd_item.char_code};
                    end
                    model_col++;
                end
                if (model_col >= COLS)
                begin
                    model_col = 0;
                    model_row++;
                end
                if (model_row >= ROW_COUNT)
                begin
                    // Scroll: every line moves up one, the last one is blanked.
                    for (int unsigned i = 0; i + COLS < CELLS; i++)
                    begin
                        screen_model[i] = screen_model[i + COLS];
                    end
                    blank_cells(CELLS - COLS, CELLS);
                    model_row = ROW_COUNT - 1;
                    rolled    = 1'b1;
                end
            end
            tcw_pkg::CMD_CLEAR:
            begin
                blank_cells(0, CELLS);
                model_col = 0;
                model_row = 0;
            end
            tcw_pkg::CMD_SET:
            begin
                // Positions off the screen leave the cursor where it is.
                if (cmd_item.new_col < COLS && cmd_item.new_row < ROW_COUNT)
                begin
                    model_col = cmd_item.new_col;
                    model_row = cmd_item.new_row;
                end
            end
            default:
            begin
                // Read cell; indexes past the store read as zero.
                if (cmd_item.cell_index < CELLS)
                begin
                    rep.cell_word = screen_model[cmd_item.cell_index];
                end
            end
        endcase
        rep.cursor_col      = 7'(model_col);
        rep.cursor_row      = 5'(model_row);
        rep.cursor_position = 11'(model_row * COLS + model_col);
        rep.scrolled        = rolled;
        return rep;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Every field random, so that fields a command ignores still toggle.
    function automatic tcw_pkg::in_item_t random_item();
        tcw_pkg::in_item_t it;
        it.command    = tcw_pkg::cmd_t'($urandom_range(0, 3));
        it.char_code  = 8'($urandom_range(0, 255));
        it.new_col    = 8'($urandom_range(0, 255));
        it.new_row    = 8'($urandom_range(0, 255));
        it.cell_index = 11'($urandom_range(0, 2047));
        return it;
    endfunction

    function automatic logic [7:0] pick_control();
        case ($urandom_range(0, 3))
            0:       return tcw_pkg::CH_NEWLINE;
            1:       return tcw_pkg::CH_RETURN;
            2:       return tcw_pkg::CH_TAB;
            default: return tcw_pkg::CH_BACKSPACE;
        endcase
    endfunction

    task automatic queue_item(tcw_pkg::in_item_t it);
        work_entry_t w;
        w.kind        = WORK_ITEM;
        w.cmd_item    = it;
        w.color_sel   = tcw_pkg::REG_FOREGROUND;
        w.color_value = 4'd0;
        command_backlog.push_back(w);
        gen_items++;
    endtask

    task automatic queue_put(logic [7:0] ch);
        tcw_pkg::in_item_t it;
        it           = random_item();
        it.command   = tcw_pkg::CMD_PUT;
        it.char_code = ch;
        queue_item(it);
    endtask

    task automatic queue_set(int col, int row);
        tcw_pkg::in_item_t it;
        it         = random_item();
        it.command = tcw_pkg::CMD_SET;
        it.new_col = 8'(col);
        it.new_row = 8'(row);
        queue_item(it);
        if (col < COLS && row < ROW_COUNT)
        begin
            gen_row = row;
        end
    endtask

    task automatic queue_read(int idx);
        tcw_pkg::in_item_t it;
        it            = random_item();
        it.command    = tcw_pkg::CMD_READ;
        it.cell_index = 11'(idx);
        queue_item(it);
    endtask

    task automatic queue_clear();
        tcw_pkg::in_item_t it;
        it         = random_item();
        it.command = tcw_pkg::CMD_CLEAR;
        queue_item(it);
    endtask

    // A drain marker, or a color write (which drains first as well).
    task automatic queue_hold(work_kind_t kind, logic sel, logic [3:0] value);
        work_entry_t w;
        w.kind        = kind;
        w.cmd_item    = '0;
        w.color_sel   = sel;
        w.color_value = value;
        command_backlog.push_back(w);
    endtask

    // ------------------------------------------------------------------------
    // Driver. An item is taken at the edge where start is high and busy is
    // low; its report is predicted right there, so the model always sees
    // items in the order the block accepts them. All next values are worked
    // out in temporaries and each output gets exactly one nonblocking write.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : item_driver
        logic               taken;
        logic               idle_now;
        logic               nx_start;
        tcw_pkg::in_item_t  nx_item;
        logic               nx_we;
        logic               nx_sel;
        logic [3:0]         nx_data;
        work_entry_t        head;
        tcw_pkg::out_item_t rep;
        if (rst_n)
        begin
            taken    = start && !busy;
            nx_start = start;
            nx_item  = item;
            nx_we    = 1'b0;
            nx_sel   = cfg_index;
            nx_data  = cfg_data;

            if (taken)
            begin
                rep = apply_console_command(item);
                expected_reports.push_back(rep);
                items_sent++;
                case (item.command)
                    tcw_pkg::CMD_PUT:   puts_sent++;
                    tcw_pkg::CMD_CLEAR: clears_sent++;
                    tcw_pkg::CMD_SET:   sets_sent++;
                    default:            reads_sent++;
                endcase
                if (rep.scrolled)
                begin
                    scrolls_due++;
                end
                // At the end of a burst choose the next one: now and then a
                // long stretch with no gaps, otherwise a short burst and a gap.
                burst_left--;
                if (burst_left <= 0)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        burst_left = $urandom_range(40, 120);
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = $urandom_range(2, 9);
                    end
                end
            end

            // A held item stays on the port untouched; otherwise pick the
            // next piece of work once any gap has run out.
            if (!start || taken)
            begin
                nx_start = 1'b0;
                // Idle means nothing in flight: no report owed, none on the
                // port this edge, and the block not busy.
                idle_now = !taken && expected_reports.size() == 0 && !done && !busy;
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (command_backlog.size() != 0)
                begin
                    head = command_backlog[0];
                    if (head.kind == WORK_ITEM)
                    begin
                        void'(command_backlog.pop_front());
                        nx_start = 1'b1;
                        nx_item  = head.cmd_item;
                    end
                    else if (idle_now)
                    begin
                        void'(command_backlog.pop_front());
                        if (head.kind == WORK_COLOR)
                        begin
                            // The register takes the value at the next edge,
                            // before any later item can be accepted.
                            nx_we   = 1'b1;
                            nx_sel  = head.color_sel;
                            nx_data = head.color_value;
                            if (head.color_sel == tcw_pkg::REG_FOREGROUND)
                            begin
                                model_fg = head.color_value;
                            end
                            else
                            begin
                                model_bg = head.color_value;
                            end
                            color_writes++;
                        end
                    end
                end
            end

            start     <= nx_start;
            item      <= nx_item;
            cfg_we    <= nx_we;
            cfg_index <= nx_sel;
            cfg_data  <= nx_data;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. A result is taken at the edge that ends its done cycle and is
    // checked field by field against the oldest outstanding report.
    // ------------------------------------------------------------------------
    task automatic note_mismatch(string what, logic [39:0] want, logic [39:0] got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h",
                     $realtime, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        tcw_pkg::out_item_t want;
        if (rst_n && done === 1'b1)
        begin
            results_seen++;
            if (expected_reports.size() == 0)
            begin
                note_mismatch("result with no item outstanding", '0, result);
            end
            else
            begin
                want = expected_reports.pop_front();
                if (result.cursor_col !== want.cursor_col)
                    note_mismatch("cursor_col", want.cursor_col, result.cursor_col);
                if (result.cursor_row !== want.cursor_row)
                    note_mismatch("cursor_row", want.cursor_row, result.cursor_row);
                if (result.cursor_position !== want.cursor_position)
                    note_mismatch("cursor_position", want.cursor_position,
                                  result.cursor_position);
                if (result.scrolled !== want.scrolled)
                    note_mismatch("scrolled", want.scrolled, result.scrolled);
                if (result.cell_word !== want.cell_word)
                    note_mismatch("cell_word", want.cell_word, result.cell_word);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: build the whole backlog, release reset, then wait for
    // the driver to empty the backlog and the monitor to collect everything.
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        int                phase_end;
        int                drain_at;
        logic              drained;
        int                roll;
        int                run_len;
        int                pick;
        logic [7:0]        ch;
        logic [3:0]        fg_value;
        logic [3:0]        bg_value;
        tcw_pkg::in_item_t it;

        reset_screen_model();

        // Directed opening, under the reset colors. The fresh store is read at
        // both ends and just past it, then each control byte is exercised.
        queue_read(0);
        queue_read(CELLS - 1);
        queue_read(CELLS);
        queue_read(2047);
        queue_put(8'h00);
        queue_put(8'hFF);
        queue_put(tcw_pkg::CH_TAB);
        queue_put("A");
        queue_put(tcw_pkg::CH_BACKSPACE);
        queue_put(tcw_pkg::CH_RETURN);
        queue_put(tcw_pkg::CH_BACKSPACE);   // Already at column 0: no move.
        queue_put(tcw_pkg::CH_NEWLINE);
        queue_read(8);                      // The 'A' survives the backspace.
        // Printing in the bottom-right corner wraps and scrolls at once.
        queue_set(COLS - 1, ROW_COUNT - 1);
        queue_put("Z");
        queue_read(CELLS - COLS - 1);       // The 'Z' moved up one line.
        // Cursor moves off the screen are ignored.
        queue_set(COLS, 0);
        queue_set(0, ROW_COUNT);
        queue_set(255, 255);
        // A tab near the right edge and a newline on the last row both scroll.
        queue_set(COLS - 4, ROW_COUNT - 1);
        queue_put(tcw_pkg::CH_TAB);
        queue_set(0, ROW_COUNT - 1);
        queue_put(tcw_pkg::CH_NEWLINE);
        queue_clear();
        queue_read(CELLS - COLS - 1);

        // Random phases, each under its own pair of colors. The two same-color
        // extremes come first, then a random pair, the mixed extremes and a random pair.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    fg_value = 4'hF;
                    bg_value = 4'hF;
                end
                1:
                begin
                    fg_value = 4'h0;
                    bg_value = 4'h0;
                end
                3:
                begin
                    fg_value = 4'hF;
                    bg_value = 4'h0;
                end
                4:
                begin
                    fg_value = 4'h0;
                    bg_value = 4'hF;
                end
                default:
                begin
                    fg_value = 4'($urandom_range(0, 15));
                    bg_value = 4'($urandom_range(0, 15));
                end
            endcase
            queue_hold(WORK_COLOR, tcw_pkg::REG_FOREGROUND, fg_value);
            queue_hold(WORK_COLOR, tcw_pkg::REG_BACKGROUND, bg_value);

            phase_end = gen_items + PHASE_ITEMS;
            drain_at  = gen_items + $urandom_range(20, PHASE_ITEMS - 20);
            drained   = 1'b0;
            while (gen_items < phase_end)
            begin
                // Once per phase the sender stops until every report is in.
                if (!drained && gen_items >= drain_at)
                begin
                    queue_hold(WORK_DRAIN, tcw_pkg::REG_FOREGROUND, 4'd0);
                    drained = 1'b1;
                end
                roll = $urandom_range(0, 99);
                if (roll < 35)
                begin
                    // A line of text: often placed near the bottom so that
                    // wraps and newlines push the screen up, mostly short,
                    // sometimes longer than a whole line.
                    if ($urandom_range(0, 1) == 1)
                    begin
                        queue_set($urandom_range(0, COLS - 1),
                                  ($urandom_range(0, 1) == 1) ?
                                  $urandom_range(ROW_COUNT - 5, ROW_COUNT - 1) :
                                  $urandom_range(0, ROW_COUNT - 1));
                    end
                    run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 90)
                                                          : $urandom_range(1, 24);
                    for (int k = 0; k < run_len; k++)
                    begin
                        ch = 8'($urandom_range(0, 255));
                        if ($urandom_range(0, 11) == 0)
                        begin
                            ch = pick_control();
                        end
                        queue_put(ch);
                    end
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                    begin
                        queue_put(tcw_pkg::CH_NEWLINE);
                    end
                    else if (pick < 8)
                    begin
                        queue_put(tcw_pkg::CH_RETURN);
                    end
                end
                else if (roll < 60)
                begin
                    // Reads: half on the row of the last on-screen cursor move, else anywhere,
                    // and now and then past the end of the store.
                    pick = $urandom_range(0, 9);
                    if (pick < 5)
                    begin
                        queue_read(gen_row * COLS + $urandom_range(0, COLS - 1));
                    end
                    else if (pick < 8)
                    begin
                        queue_read($urandom_range(0, CELLS - 1));
                    end
                    else
                    begin
                        queue_read($urandom_range(0, 2047));
                    end
                end
                else if (roll < 75)
                begin
                    if ($urandom_range(0, 99) < 65)
                    begin
                        queue_set($urandom_range(0, COLS - 1),
                                  $urandom_range(0, ROW_COUNT - 1));
                    end
                    else
                    begin
                        queue_set($urandom_range(0, 255), $urandom_range(0, 255));
                    end
                end
                else if (roll < 85)
                begin
                    queue_put(pick_control());
                end
                else if (roll < 88)
                begin
                    queue_clear();
                end
                else
                begin
                    // Noise: any command with any field values.
                    it = random_item();
                    queue_item(it);
                end
            end
        end

        // Single reset pulse, released on a rising edge.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Sample on falling edges so that nothing here races the driver.
        do @(negedge clk); while (command_backlog.size() != 0 || start);
        while (expected_reports.size() != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Ran %0d items (%0d puts, %0d clears, %0d cursor moves, %0d reads).",
                 items_sent, puts_sent, clears_sent, sets_sent, reads_sent);
        $display("Checked %0d results, %0d scrolls, %0d color writes, %0d mismatches.",
                 results_seen, scrolls_due, color_writes, mismatches);
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin : watchdog
        #(TIME_LIMIT_NS);
        $display("Timed out with %0d items pending and %0d results outstanding.",
                 command_backlog.size(), expected_reports.size());
        $display("FAILURE");
        $finish;
    end

endmodule
